/* src/level_rise_event_detector_macros.svh */
// Assertion macros shared by the level rise event detector.
`ifndef LEVEL_RISE_EVENT_DETECTOR_MACROS_SVH
`define LEVEL_RISE_EVENT_DETECTOR_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LED_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/led_pkg.sv */
// Package with widths, register map, reset values and item types of the detector.
package led_pkg;

    localparam int LEVEL_BITS = 17;
    localparam int TIME_BITS  = 32;
    localparam int RATE_BITS  = 17;
    localparam int MPM_BITS   = 16;
    localparam int LHS_BITS   = LEVEL_BITS + MPM_BITS;
    localparam int PROD_BITS  = RATE_BITS + TIME_BITS;
    localparam int ADDR_BITS  = 4;
    localparam int DATA_BITS  = 32;

    localparam logic [MPM_BITS-1:0] MS_PER_MIN = MPM_BITS'(60000);

    localparam logic [LEVEL_BITS-1:0] MIN_RISE_RST  = LEVEL_BITS'(5000);
    localparam logic [TIME_BITS-1:0]  MAX_AGE_RST   = TIME_BITS'(1800000);
    localparam logic [TIME_BITS-1:0]  CONFIRM_RST   = TIME_BITS'(60000);
    localparam logic [RATE_BITS-1:0]  MAX_RATE_RST  = RATE_BITS'(15000);

    typedef enum logic [1:0] {
        REG_MIN_RISE,
        REG_MAX_CANDIDATE_AGE,
        REG_CONFIRM_TIME,
        REG_MAX_RATE
    } reg_idx_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] min_rise;
        logic [TIME_BITS-1:0]  max_candidate_age;
        logic [TIME_BITS-1:0]  confirm_time;
        logic [RATE_BITS-1:0]  max_rate;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] level;
        logic                  level_valid;
        logic [TIME_BITS-1:0]  time_ms;
    } sample_t;

    typedef struct packed {
        logic                  refill_found;
        logic [LEVEL_BITS-1:0] rise_amount;
    } result_t;

    typedef struct packed {
        logic prev_seen;
        logic cand_active;
    } det_status_t;

endpackage

/* src/led_cfg.sv */
// APB configuration register bank of the detector.
module led_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [led_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [led_pkg::DATA_BITS-1:0]  pwdata,
    output logic [led_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    output led_pkg::cfg_t                  cfg
);

    led_pkg::cfg_t    cfg_reg;
    led_pkg::cfg_t    cfg_next;
    led_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx    = led_pkg::reg_idx_t'(paddr[led_pkg::ADDR_BITS-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                led_pkg::REG_MIN_RISE:
                    cfg_next.min_rise = pwdata[led_pkg::LEVEL_BITS-1:0];
                led_pkg::REG_MAX_CANDIDATE_AGE:
                    cfg_next.max_candidate_age = pwdata[led_pkg::TIME_BITS-1:0];
                led_pkg::REG_CONFIRM_TIME:
                    cfg_next.confirm_time = pwdata[led_pkg::TIME_BITS-1:0];
                led_pkg::REG_MAX_RATE:
                    cfg_next.max_rate = pwdata[led_pkg::RATE_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            led_pkg::REG_MIN_RISE:
                prdata = led_pkg::DATA_BITS'(cfg_reg.min_rise);
            led_pkg::REG_MAX_CANDIDATE_AGE:
                prdata = led_pkg::DATA_BITS'(cfg_reg.max_candidate_age);
            led_pkg::REG_CONFIRM_TIME:
                prdata = led_pkg::DATA_BITS'(cfg_reg.confirm_time);
            led_pkg::REG_MAX_RATE:
                prdata = led_pkg::DATA_BITS'(cfg_reg.max_rate);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_rise          <= led_pkg::MIN_RISE_RST;
            cfg_reg.max_candidate_age <= led_pkg::MAX_AGE_RST;
            cfg_reg.confirm_time      <= led_pkg::CONFIRM_RST;
            cfg_reg.max_rate          <= led_pkg::MAX_RATE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* src/led_rate_chk.sv */
// Rise detection and fill rate plausibility check against the previous sample.
module led_rate_chk (
    input  logic [led_pkg::LEVEL_BITS-1:0] level,
    input  logic [led_pkg::TIME_BITS-1:0]  time_ms,
    input  logic [led_pkg::LEVEL_BITS-1:0] prev_level,
    input  logic [led_pkg::TIME_BITS-1:0]  prev_time,
    input  logic [led_pkg::RATE_BITS-1:0]  max_rate,
    output logic                           rising,
    output logic                           plausible
);

    logic [led_pkg::LEVEL_BITS-1:0] rise;
    logic [led_pkg::TIME_BITS-1:0]  dt;
    logic [led_pkg::LHS_BITS-1:0]   lhs;
    logic [led_pkg::PROD_BITS-1:0]  rhs;
    logic                           too_fast;

    assign rising = level > prev_level;
    assign rise   = level - prev_level;

    // Time running backwards counts as no elapsed time.
    assign dt = (time_ms >= prev_time) ? (time_ms - prev_time) : '0;

    assign lhs = {{led_pkg::MPM_BITS{1'b0}}, rise}
               * {{led_pkg::LEVEL_BITS{1'b0}}, led_pkg::MS_PER_MIN};
    assign rhs = {{led_pkg::TIME_BITS{1'b0}}, max_rate}
               * {{led_pkg::RATE_BITS{1'b0}}, dt};

    assign too_fast  = led_pkg::PROD_BITS'(lhs) > rhs;
    assign plausible = (dt == '0) || !too_fast;

endmodule

/* src/led_cand.sv */
// Candidate tracking state and the per-item update that produces the result.
module led_cand (
    input  logic                 clk,
    input  logic                 rst_n,
    input  led_pkg::cfg_t        cfg,
    input  led_pkg::sample_t     sample,
    input  logic                 advance,
    output led_pkg::result_t     res_next,
    output led_pkg::det_status_t status
);

    logic [led_pkg::LEVEL_BITS-1:0] prev_level_reg, prev_level_next;
    logic [led_pkg::TIME_BITS-1:0]  prev_time_reg, prev_time_next;
    logic                           prev_seen_reg, prev_seen_next;
    logic                           cand_active_reg, cand_active_next;
    logic [led_pkg::TIME_BITS-1:0]  cand_start_reg, cand_start_next;
    logic [led_pkg::LEVEL_BITS-1:0] base_level_reg, base_level_next;
    logic [led_pkg::LEVEL_BITS-1:0] peak_level_reg, peak_level_next;

    logic                           rising;
    logic                           plausible;
    logic [led_pkg::TIME_BITS-1:0]  elapsed;
    logic [led_pkg::LEVEL_BITS-1:0] net;
    logic [led_pkg::LEVEL_BITS-1:0] fall;

    led_rate_chk u_rate_chk (
        .level      (sample.level),
        .time_ms    (sample.time_ms),
        .prev_level (prev_level_reg),
        .prev_time  (prev_time_reg),
        .max_rate   (cfg.max_rate),
        .rising     (rising),
        .plausible  (plausible)
    );

    always_comb
    begin
        prev_level_next  = prev_level_reg;
        prev_time_next   = prev_time_reg;
        prev_seen_next   = prev_seen_reg;
        cand_active_next = cand_active_reg;
        cand_start_next  = cand_start_reg;
        base_level_next  = base_level_reg;
        peak_level_next  = peak_level_reg;
        elapsed          = sample.time_ms - cand_start_reg;
        net              = '0;
        fall             = '0;
        res_next         = '0;

        if (sample.level_valid)
        begin
            prev_level_next = sample.level;
            prev_time_next  = sample.time_ms;
            prev_seen_next  = 1'b1;

            if (prev_seen_reg)
            begin
                if (cand_active_reg && (elapsed > cfg.max_candidate_age))
                begin
                    cand_active_next = 1'b0;
                end

                if (!cand_active_next && rising && plausible)
                begin
                    cand_active_next = 1'b1;
                    cand_start_next  = sample.time_ms;
                    base_level_next  = prev_level_reg;
                    peak_level_next  = sample.level;
                    elapsed          = '0;
                end

                if (cand_active_next)
                begin
                    if (sample.level > peak_level_next)
                    begin
                        peak_level_next = sample.level;
                    end
                    net = (peak_level_next >= base_level_next)
                        ? (peak_level_next - base_level_next) : '0;

                    if ((net >= cfg.min_rise) && (elapsed >= cfg.confirm_time))
                    begin
                        res_next.refill_found = 1'b1;
                        res_next.rise_amount  = net;
                        cand_active_next      = 1'b0;
                    end
                    else
                    begin
                        fall = (peak_level_next >= sample.level)
                             ? (peak_level_next - sample.level) : '0;
                        if ((fall > cfg.min_rise) && (net < cfg.min_rise))
                        begin
                            cand_active_next = 1'b0;
                        end
                    end
                end
            end
        end
    end

    assign status.prev_seen   = prev_seen_reg;
    assign status.cand_active = cand_active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_seen_reg   <= 1'b0;
            cand_active_reg <= 1'b0;
        end
        else if (advance)
        begin
            prev_seen_reg   <= prev_seen_next;
            cand_active_reg <= cand_active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prev_level_reg <= prev_level_next;
            prev_time_reg  <= prev_time_next;
            cand_start_reg <= cand_start_next;
            base_level_reg <= base_level_next;
            peak_level_reg <= peak_level_next;
        end
    end

endmodule

/* src/level_rise_event_detector.sv */
// Top level of the tank refill detector: input and result registers and APB port.
//
//   channel   direction  handshake                    payload
//   sample    in         sample_valid / sample_stall  level, level_valid, time_ms
//   result    out        result_valid / result_stall  refill_found, rise_amount
//   config    in         APB psel / penable / pready  paddr, pwdata, prdata
//
// One item is accepted per cycle while sample_stall is low; each item gives exactly
// one result item. Items pass through the input register, then the candidate
// update logic, whose rate multiplier sets the clock, into the result register.
// A stalled result holds both registers; the input stalls only when both are full.
// Reset clears the control flags and loads the register defaults; no clearing pass.
module level_rise_event_detector (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic [led_pkg::LEVEL_BITS-1:0] level,
    input  logic                           level_valid,
    input  logic [led_pkg::TIME_BITS-1:0]  time_ms,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic                           refill_found,
    output logic [led_pkg::LEVEL_BITS-1:0] rise_amount,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [led_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [led_pkg::DATA_BITS-1:0]  pwdata,
    output logic [led_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready
);

    `include "level_rise_event_detector_macros.svh"

    led_pkg::cfg_t          cfg;
    led_pkg::sample_t       sample_reg;
    logic                   s1_valid_reg, s1_valid_next;
    led_pkg::result_t       result_reg;
    logic                   result_valid_reg, result_valid_next;
    led_pkg::result_t       res_next;
    led_pkg::det_status_t   status;
    logic                   s2_ready;
    logic                   s1_ready;
    logic                   advance;
    logic                   accept;

    led_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    led_cand u_cand (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .sample   (sample_reg),
        .advance  (advance),
        .res_next (res_next),
        .status   (status)
    );

    assign s2_ready     = !result_valid_reg || !result_stall;
    assign advance      = s1_valid_reg && s2_ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign sample_stall = !s1_ready;
    assign accept       = sample_valid && s1_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (s2_ready)
        begin
            result_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg.level       <= level;
            sample_reg.level_valid <= level_valid;
            sample_reg.time_ms     <= time_ms;
        end
        if (advance)
        begin
            result_reg <= res_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign refill_found = result_reg.refill_found;
    assign rise_amount  = result_reg.rise_amount;

    `LED_ASSERT_SAME(a_quiet_zero, result_valid && !refill_found, rise_amount == '0,
        "A result without a refill carries a nonzero rise.")
    `LED_ASSERT_SAME(a_rise_min, result_valid && refill_found, rise_amount >= cfg.min_rise,
        "A confirmed refill is smaller than the minimum rise.")
    `LED_ASSERT_NEXT(a_refill_ends, advance && res_next.refill_found, !status.cand_active,
        "The candidate is still active after its refill was confirmed.")
    `LED_ASSERT_NEXT(a_no_loss, advance, result_valid,
        "An item left the input register without producing a result.")

endmodule
